/* rtl/bitmap_8bit_pixel_stream_decoder_top_defines.svh */
// Assertion macros used by the decoder checker.
`ifndef BITMAP_8BIT_PIXEL_STREAM_DECODER_TOP_DEFINES_SVH
`define BITMAP_8BIT_PIXEL_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define BMPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset.
`define BMPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bmpd_pkg.sv */
// Types and constants shared by the bitmap pixel stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package bmpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int DIM_W      = 13;
  localparam int DIM_MAX    = (1 << DIM_W) - 1;
  localparam int ADDR_OUT_W = 24;
  localparam int PROD_W     = BYTE_W + DIM_W;
  localparam int CFG_IDX_W  = 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  // raw rows are padded to a multiple of 4 bytes
  localparam logic [DIM_W:0] STRIDE_MASK = {{(DIM_W - 1){1'b1}}, 2'b00};

  localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [BYTE_W-1:0] ESC_END   = 8'd1;
  localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH      = 2'd0,
    REG_IMAGE_HEIGHT     = 2'd1,
    REG_COMPRESSION_MODE = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_PAIR   = 3'd0,
    PH_RUNVAL = 3'd1,
    PH_ESC    = 3'd2,
    PH_DX     = 3'd3,
    PH_DY     = 3'd4,
    PH_LIT    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    OP_SKIP  = 3'd0,
    OP_RAW   = 3'd1,
    OP_FILL  = 3'd2,
    OP_EOL   = 3'd3,
    OP_END   = 3'd4,
    OP_DELTA = 3'd5
  } op_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] count;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  col_next;
    logic              wrote;
    logic              wrap;
    logic [BYTE_W-1:0] dx;
    logic [PROD_W-1:0] prod;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic             rle;
  } geom_t;

endpackage

`default_nettype wire

/* rtl/bmpd_cfg.sv */
// Configuration registers and the geometry derived from them.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_cfg #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int AW         = 26
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bmpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bmpd_pkg::DIM_W-1:0]     cfg_data,
  output bmpd_pkg::geom_t                     geom,
  output logic signed [AW-1:0]                area,
  output logic signed [AW-1:0]                top_row,
  output logic                                settle
);
  import bmpd_pkg::*;

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic               compression_mode;
  logic [DIM_W-1:0]   eff_w;
  logic [DIM_W-1:0]   eff_h;
  logic [DIM_W-1:0]   w_clamp;
  logic [DIM_W-1:0]   h_clamp;
  logic [DIM_W-1:0]   h_less;
  logic [2*DIM_W-1:0] area_prod;
  logic [2*DIM_W-1:0] top_prod;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (image_width == '0) begin
      w_clamp = DIM_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_clamp = DIM_W'(MAX_WIDTH);
    end else begin
      w_clamp = image_width;
    end
    if (image_height == '0) begin
      h_clamp = DIM_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_clamp = DIM_W'(MAX_HEIGHT);
    end else begin
      h_clamp = image_height;
    end
  end

  assign h_less    = eff_h - DIM_W'(1);
  assign area_prod = (2*DIM_W)'(eff_w) * (2*DIM_W)'(eff_h);
  assign top_prod  = (2*DIM_W)'(h_less) * (2*DIM_W)'(eff_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= DIM_W'(1);
      image_height     <= DIM_W'(1);
      compression_mode <= 1'b0;
      eff_w            <= DIM_W'(1);
      eff_h            <= DIM_W'(1);
      area             <= AW'(1);
      top_row          <= '0;
      settle           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_index_t'(cfg_index))
          REG_IMAGE_WIDTH:      image_width      <= cfg_data;
          REG_IMAGE_HEIGHT:     image_height     <= cfg_data;
          REG_COMPRESSION_MODE: compression_mode <= cfg_data[0];
          default: ;
        endcase
      end
      settle  <= cfg_valid && cfg_ready;
      eff_w   <= w_clamp;
      eff_h   <= h_clamp;
      area    <= AW'(area_prod);
      top_row <= AW'(top_prod);
    end
  end

  assign geom = '{width: eff_w, rle: compression_mode};

endmodule

`default_nettype wire

/* rtl/bmpd_front.sv */
// Front end: byte parser that turns each byte into a command for the back end.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [bmpd_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                        start_of_image,
  input  wire bmpd_pkg::geom_t             geom,
  output bmpd_pkg::cmd_t                   cmd
);
  import bmpd_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [DIM_W-1:0]  col;
  logic [DIM_W-1:0]  col_next;
  logic [BYTE_W-1:0] pend;
  logic [BYTE_W-1:0] pend_next;
  logic [BYTE_W-1:0] dx;
  logic [BYTE_W-1:0] dx_next;

  phase_t            ph;
  logic [DIM_W-1:0]  c;
  logic [BYTE_W-1:0] pd;
  logic [BYTE_W-1:0] dxv;
  logic [DIM_W:0]    c_inc;
  logic [DIM_W:0]    stride;
  logic              raw_wrap;
  logic              raw_wrote;
  logic [BYTE_W:0]   lit_len;
  logic [DIM_W-1:0]  lit_next;
  logic              lit_done;

  // a start byte sees a freshly reset parser
  assign ph  = start_of_image ? PH_PAIR : phase;
  assign c   = start_of_image ? '0 : col;
  assign pd  = start_of_image ? '0 : pend;
  assign dxv = start_of_image ? '0 : dx;

  assign c_inc     = {1'b0, c} + (DIM_W+1)'(1);
  assign stride    = ({1'b0, geom.width} + (DIM_W+1)'(3)) & STRIDE_MASK;
  assign raw_wrap  = c_inc >= stride;
  assign raw_wrote = c < geom.width;
  assign lit_len   = ({1'b0, pd} + (BYTE_W+1)'(1)) & ~(BYTE_W+1)'(1);
  assign lit_next  = c_inc[DIM_W-1:0];
  assign lit_done  = (lit_next >= DIM_W'(lit_len)) || (lit_next == '0);

  // next state
  always_comb begin
    phase_next = ph;
    col_next   = c;
    pend_next  = pd;
    dx_next    = dxv;
    if (!geom.rle) begin
      col_next = raw_wrap ? '0 : c_inc[DIM_W-1:0];
    end else begin
      unique case (ph)
        PH_PAIR: begin
          if (data_byte != '0) begin
            pend_next  = data_byte;
            phase_next = PH_RUNVAL;
          end else begin
            phase_next = PH_ESC;
          end
        end
        PH_RUNVAL: phase_next = PH_PAIR;
        PH_ESC: begin
          phase_next = PH_PAIR;
          if (data_byte == ESC_DELTA) begin
            phase_next = PH_DX;
          end else if (data_byte != ESC_EOL && data_byte != ESC_END) begin
            pend_next  = data_byte;
            col_next   = '0;
            phase_next = PH_LIT;
          end
        end
        PH_DX: begin
          dx_next    = data_byte;
          phase_next = PH_DY;
        end
        PH_DY: phase_next = PH_PAIR;
        PH_LIT: begin
          col_next = lit_next;
          if (lit_done) phase_next = PH_PAIR;
        end
        default: phase_next = PH_PAIR;
      endcase
    end
  end

  // command for the back end
  always_comb begin
    cmd          = '0;
    cmd.start    = start_of_image;
    cmd.op       = OP_SKIP;
    cmd.value    = data_byte;
    cmd.col      = c;
    cmd.col_next = col_next;
    cmd.wrote    = raw_wrote;
    cmd.wrap     = raw_wrap;
    cmd.dx       = dxv;
    cmd.prod     = PROD_W'(data_byte) * PROD_W'(geom.width);
    if (!geom.rle) begin
      cmd.op = OP_RAW;
    end else begin
      unique case (ph)
        PH_RUNVAL: begin
          cmd.op    = OP_FILL;
          cmd.count = pd;
        end
        PH_ESC: begin
          if (data_byte == ESC_EOL) begin
            cmd.op = OP_EOL;
          end else if (data_byte == ESC_END) begin
            cmd.op = OP_END;
          end
        end
        PH_DY: cmd.op = OP_DELTA;
        PH_LIT: begin
          if (c < DIM_W'(pd)) begin
            cmd.op    = OP_FILL;
            cmd.count = BYTE_W'(1);
          end
        end
        default: cmd.op = OP_SKIP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PAIR;
      col   <= '0;
      pend  <= '0;
      dx    <= '0;
    end else if (push) begin
      phase <= phase_next;
      col   <= col_next;
      pend  <= pend_next;
      dx    <= dx_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/bmpd_queue.sv */
// Command queue between the parser and the address unit.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bmpd_pkg::cmd_t wdata,
  input  wire logic           pop,
  output bmpd_pkg::cmd_t      rdata,
  output logic                not_empty,
  output logic                full
);
  import bmpd_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  assign rdata     = slots[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == (QPTR_W+1)'(QDEPTH);

endmodule

`default_nettype wire

/* rtl/bmpd_back.sv */
// Back end: write position tracking, clipping and the result register.
`timescale 1ns / 1ps
`default_nettype none

module bmpd_back #(
  parameter int AW = 26
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  wire bmpd_pkg::cmd_t                  cmd,
  output logic                                 pop,
  input  wire bmpd_pkg::geom_t                 geom,
  input  wire logic signed [AW-1:0]            area,
  input  wire logic signed [AW-1:0]            top_row,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bmpd_pkg::ADDR_OUT_W-1:0]      pixel_address,
  output logic [bmpd_pkg::BYTE_W-1:0]          pixel_value,
  output logic [bmpd_pkg::BYTE_W-1:0]          repeat_count,
  output logic                                 clipped,
  output logic                                 image_done
);
  import bmpd_pkg::*;

  logic signed [AW-1:0] row_start;
  logic signed [AW-1:0] row_start_next;
  logic signed [AW-1:0] write_address;
  logic signed [AW-1:0] write_address_next;
  logic                 finished;
  logic                 finished_next;

  logic signed [AW-1:0] rs;
  logic signed [AW-1:0] wa;
  logic                 fin;
  logic signed [AW-1:0] w_s;
  logic signed [AW-1:0] col_s;
  logic signed [AW-1:0] coln_s;
  logic signed [AW-1:0] dx_s;
  logic signed [AW-1:0] prod_s;
  logic signed [AW-1:0] n_s;
  logic signed [AW-1:0] a_raw;
  logic signed [AW-1:0] rs_wrap;
  logic signed [AW-1:0] fill_end;
  logic signed [AW-1:0] room;
  logic signed [AW-1:0] ce_wa;
  logic signed [AW-1:0] ce_rs;
  logic                 in_buf;

  logic                 res_valid;
  logic signed [AW-1:0] res_addr;
  logic [BYTE_W-1:0]    res_value;
  logic [BYTE_W-1:0]    res_count;
  logic                 res_clip;
  logic                 res_done;

  assign pop = q_valid && (!out_valid || out_ready);

  assign rs  = cmd.start ? top_row : row_start;
  assign wa  = cmd.start ? top_row : write_address;
  assign fin = cmd.start ? 1'b0 : finished;

  assign w_s    = AW'(geom.width);
  assign col_s  = AW'(cmd.col);
  assign coln_s = AW'(cmd.col_next);
  assign dx_s   = AW'(cmd.dx);
  assign prod_s = AW'(cmd.prod);
  assign n_s    = AW'(cmd.count);

  assign a_raw    = rs + col_s;
  assign rs_wrap  = rs - w_s;
  assign fill_end = wa + n_s;
  assign room     = area - wa;
  assign in_buf   = !a_raw[AW-1] && (a_raw < area);
  assign ce_rs    = (cmd.op == OP_EOL) ? rs_wrap : rs - prod_s;
  assign ce_wa    = (cmd.op == OP_EOL) ? rs_wrap : wa + dx_s - prod_s;

  always_comb begin
    row_start_next     = rs;
    write_address_next = wa;
    finished_next      = fin;
    res_valid          = 1'b0;
    res_addr           = '0;
    res_value          = '0;
    res_count          = '0;
    res_clip           = 1'b0;
    res_done           = 1'b0;
    if (!fin) begin
      unique case (cmd.op)
        OP_RAW: begin
          if (cmd.wrap) row_start_next = rs_wrap;
          finished_next      = cmd.wrap && rs_wrap[AW-1];
          write_address_next = row_start_next + coln_s;
          if (cmd.wrote) begin
            res_valid = 1'b1;
            res_addr  = a_raw;
            res_value = cmd.value;
            res_count = in_buf ? BYTE_W'(1) : '0;
            res_clip  = !in_buf;
            res_done  = finished_next;
          end else if (finished_next) begin
            res_valid = 1'b1;
            res_done  = 1'b1;
          end
        end
        OP_FILL: begin
          res_valid = 1'b1;
          res_value = cmd.value;
          if (wa[AW-1] || wa >= area) begin
            res_clip = cmd.count != '0;
          end else if (n_s > room) begin
            // cut at the buffer end; a run longer than the whole buffer reports address 0
            res_count = room[BYTE_W-1:0];
            res_clip  = 1'b1;
            res_addr  = (n_s > area) ? '0 : wa;
          end else begin
            res_count = cmd.count;
            res_addr  = wa;
          end
          if (!wa[AW-1]) write_address_next = (fill_end > area) ? area : fill_end;
        end
        OP_EOL, OP_DELTA: begin
          row_start_next     = ce_rs;
          write_address_next = (ce_wa > area) ? area : ce_wa;
          if (ce_wa[AW-1] || ce_rs[AW-1]) begin
            finished_next = 1'b1;
            res_valid     = 1'b1;
            res_done      = 1'b1;
          end
        end
        OP_END: begin
          finished_next = 1'b1;
          res_valid     = 1'b1;
          res_done      = 1'b1;
        end
        default: ;
      endcase
    end
    if (res_count == '0) begin
      res_addr  = '0;
      res_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      finished      <= 1'b1;
      row_start     <= '0;
      write_address <= '0;
    end else if (pop) begin
      out_valid     <= res_valid;
      finished      <= finished_next;
      row_start     <= row_start_next;
      write_address <= write_address_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      pixel_address <= ADDR_OUT_W'(res_addr);
      pixel_value   <= res_value;
      repeat_count  <= res_count;
      clipped       <= res_clip;
      image_done    <= res_done;
    end
  end

endmodule

`default_nettype wire

/* rtl/bitmap_8bit_pixel_stream_decoder_top.sv */
// Top level of the 8-bit bitmap pixel stream decoder.
// Takes one pixel-data byte per clock while in_ready is high and returns at most one fill
// command per byte, in order, registered as the byte leaves the 4-entry command queue; with
// a free output the sustained rate is one byte per clock. The parser stage and the address
// stage each sit on their own side of the queue, and the queue takes bytes while an earlier
// fill command waits for out_ready. After each configuration transaction the input is held
// off while the buffer area and the top row address, each a 13x13 product, are recomputed.
// A byte with start_of_image high restarts decoding at the bottom row; before the first
// start and after the image ends, bytes are taken and dropped.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_8bit_pixel_stream_decoder_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bmpd_pkg::BYTE_W-1:0]     data_byte,
  input  wire logic                            start_of_image,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bmpd_pkg::ADDR_OUT_W-1:0]      pixel_address,
  output logic [bmpd_pkg::BYTE_W-1:0]          pixel_value,
  output logic [bmpd_pkg::BYTE_W-1:0]          repeat_count,
  output logic                                 clipped,
  output logic                                 image_done,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bmpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bmpd_pkg::DIM_W-1:0]      cfg_data
);
  import bmpd_pkg::*;

  localparam int EFF_MAX_W = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int EFF_MAX_H = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int AREA_MAX  = EFF_MAX_W * EFF_MAX_H;
  localparam int SPAN_BITS = $clog2(AREA_MAX + 1024);
  localparam int STEP_BITS = $clog2(256 * EFF_MAX_W);
  localparam int AW        = ((SPAN_BITS > STEP_BITS) ? SPAN_BITS : STEP_BITS) + 1;

  geom_t                geom;
  logic signed [AW-1:0] area;
  logic signed [AW-1:0] top_row;
  logic                 settle;
  logic                 push;
  logic                 pop;
  logic                 q_valid;
  logic                 q_full;
  cmd_t                 front_cmd;
  cmd_t                 head_cmd;

  assign in_ready = !q_full && !settle;
  assign push     = in_valid && in_ready;

  bmpd_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .geom     (geom),
    .area     (area),
    .top_row  (top_row),
    .settle   (settle)
  );

  bmpd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .data_byte     (data_byte),
    .start_of_image(start_of_image),
    .geom          (geom),
    .cmd           (front_cmd)
  );

  bmpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (front_cmd),
    .pop      (pop),
    .rdata    (head_cmd),
    .not_empty(q_valid),
    .full     (q_full)
  );

  bmpd_back #(
    .AW(AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .cmd          (head_cmd),
    .pop          (pop),
    .geom         (geom),
    .area         (area),
    .top_row      (top_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_address(pixel_address),
    .pixel_value  (pixel_value),
    .repeat_count (repeat_count),
    .clipped      (clipped),
    .image_done   (image_done)
  );

endmodule

`default_nettype wire

/* rtl/bmpd_checker.sv */
// Port-level checker for the decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_8bit_pixel_stream_decoder_top_defines.svh"

module bmpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] pixel_address,
  input wire logic [7:0]  pixel_value,
  input wire logic [7:0]  repeat_count,
  input wire logic        clipped,
  input wire logic        image_done,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  `BMPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready && !rst, out_valid && $stable(pixel_address) && $stable(pixel_value) && $stable(repeat_count) && $stable(clipped) && $stable(image_done), "stalled transaction changed")

  `BMPD_ASSERT_NOW(a_empty_fill_zero, out_valid && repeat_count == 8'd0, pixel_address == 24'd0 && pixel_value == 8'd0, "empty fill carries address or value")

  `BMPD_ASSERT_NOW(a_done_short, out_valid && image_done, repeat_count <= 8'd1, "end of image with a multi-pixel fill")

  `BMPD_ASSERT_NEXT(a_cfg_holdoff, cfg_valid && cfg_ready && !rst, !in_ready, "input taken right after a configuration write")

  `BMPD_ASSERT_NEXT(a_reset_quiet, rst, !out_valid, "result valid right after reset")

endmodule

bind bitmap_8bit_pixel_stream_decoder_top bmpd_checker u_bmpd_checker (.*);

`default_nettype wire

/* dv/bitmap_8bit_pixel_stream_decoder_top_test.sv */
// Self-checking testbench for the 8-bit bitmap pixel stream decoder top level.
`timescale 1ns / 1ps

module bitmap_8bit_pixel_stream_decoder_top_test;
  import bmpd_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam int IDLE_PCT = 13;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [BYTE_W-1:0] ESC_LEAD = 8'd0;
  localparam int LIT_MIN = 3;

  typedef struct packed {
    logic [ADDR_OUT_W-1:0] addr;
    logic [BYTE_W-1:0]     value;
    logic [BYTE_W-1:0]     count;
    logic                  clip;
    logic                  done;
  } fill_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              sof;
  } byte_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     value;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic start_of_image = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_OUT_W-1:0] pixel_address;
  logic [BYTE_W-1:0] pixel_value;
  logic [BYTE_W-1:0] repeat_count;
  logic clipped;
  logic image_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  byte_item_t byte_q[$];
  reg_write_t cfg_q[$];
  fill_cmd_t  expected_q[$];

  // decoder model state
  logic [DIM_W-1:0] cfg_w = 13'd1;
  logic [DIM_W-1:0] cfg_h = 13'd1;
  logic cfg_rle = 1'b0;
  phase_t parse_state = PH_PAIR;
  longint wr_addr = 0;
  longint row_base = 0;
  longint col_cnt = 0;
  longint pend = 0;
  longint dx_pend = 0;
  bit halted = 1'b1;

  int decoded_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit no_gaps = 1'b0;
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;
  bit pending_start = 1'b0;

  bitmap_8bit_pixel_stream_decoder_top #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .start_of_image(start_of_image),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_address(pixel_address),
    .pixel_value(pixel_value),
    .repeat_count(repeat_count),
    .clipped(clipped),
    .image_done(image_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic longint eff_width();
    longint w = cfg_w;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic longint eff_height();
    longint h = cfg_h;
    if (h < 1) h = 1;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  function automatic fill_cmd_t make_cmd(input longint addr, input logic [BYTE_W-1:0] value,
                                         input longint cnt, input logic clip,
                                         input logic done);
    fill_cmd_t c;
    c.addr  = (cnt == 0) ? '0 : addr[ADDR_OUT_W-1:0];
    c.value = (cnt == 0) ? '0 : value;
    c.count = cnt[BYTE_W-1:0];
    c.clip  = clip;
    c.done  = done;
    return c;
  endfunction

  function automatic fill_cmd_t run_fill(input logic [BYTE_W-1:0] value, input longint n,
                                         input logic done);
    longint size, a, cnt, addr;
    logic clip;
    size = eff_width() * eff_height();
    a = wr_addr;
    cnt = n;
    clip = 1'b0;
    if (a < 0 || a >= size) begin
      cnt = 0;
      clip = (n != 0);
    end else if (n > size - a) begin
      cnt = size - a;
      clip = 1'b1;
    end
    if (a >= 0) begin
      a += n;
      if (a > size) a = size;
      wr_addr = a;
    end
    if (wr_addr - n < 0) addr = 0;
    else if (a >= size && cnt < n) addr = (cnt != 0) ? size - cnt : 0;
    else addr = a - n;
    return make_cmd(addr, value, cnt, clip, done);
  endfunction

  function automatic bit end_check(output fill_cmd_t cmd);
    longint size;
    size = eff_width() * eff_height();
    cmd = '0;
    if (wr_addr > size) wr_addr = size;
    if (wr_addr < 0 || row_base < 0) begin
      halted = 1'b1;
      parse_state = PH_PAIR;
      cmd = make_cmd(0, '0, 0, 1'b0, 1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advances the model by one byte; returns 1 when the byte yields a fill command
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic sof,
                                     output fill_cmd_t cmd);
    longint w, h, bv, a, stride, idx;
    bit wrote, in_buf;
    cmd = '0;
    w = eff_width();
    h = eff_height();
    bv = b;
    if (sof) begin
      parse_state = PH_PAIR;
      row_base = (h - 1) * w;
      wr_addr = row_base;
      col_cnt = 0;
      pend = 0;
      dx_pend = 0;
      halted = 1'b0;
    end
    if (halted) return 1'b0;
    decoded_count++;
    if (!cfg_rle) begin
      stride = ((w + 3) >> 2) << 2;
      wrote = col_cnt < w;
      a = row_base + col_cnt;
      col_cnt++;
      if (col_cnt >= stride) begin
        col_cnt = 0;
        row_base -= w;
        if (row_base < 0) halted = 1'b1;
      end
      wr_addr = row_base + col_cnt;
      if (wrote) begin
        in_buf = a >= 0 && a < w * h;
        cmd = make_cmd(a, b, in_buf ? 1 : 0, !in_buf, halted);
        return 1'b1;
      end
      if (halted) begin
        cmd = make_cmd(0, '0, 0, 1'b0, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    case (parse_state)
      PH_PAIR: begin
        if (b != ESC_LEAD) begin
          pend = bv;
          parse_state = PH_RUNVAL;
        end else begin
          parse_state = PH_ESC;
        end
        return 1'b0;
      end
      PH_RUNVAL: begin
        parse_state = PH_PAIR;
        cmd = run_fill(b, pend, 1'b0);
        return 1'b1;
      end
      PH_ESC: begin
        parse_state = PH_PAIR;
        if (b == ESC_EOL) begin
          row_base -= w;
          wr_addr = row_base;
          return end_check(cmd);
        end
        if (b == ESC_END) begin
          halted = 1'b1;
          cmd = make_cmd(0, '0, 0, 1'b0, 1'b1);
          return 1'b1;
        end
        if (b == ESC_DELTA) begin
          parse_state = PH_DX;
          return 1'b0;
        end
        pend = bv;
        col_cnt = 0;
        parse_state = PH_LIT;
        return 1'b0;
      end
      PH_DX: begin
        dx_pend = bv;
        parse_state = PH_DY;
        return 1'b0;
      end
      PH_DY: begin
        wr_addr += dx_pend - bv * w;
        row_base -= bv * w;
        parse_state = PH_PAIR;
        return end_check(cmd);
      end
      PH_LIT: begin
        idx = col_cnt;
        col_cnt = (col_cnt + 1) & 'h1FFF;
        if (col_cnt >= (((pend + 1) >> 1) << 1) || col_cnt == 0) parse_state = PH_PAIR;
        if (idx < pend) begin
          cmd = run_fill(b, 1, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        parse_state = PH_PAIR;
        return 1'b0;
      end
    endcase
  endfunction

  // byte driver
  always @(posedge clk) begin
    byte_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
        it = byte_q.pop_front();
        in_valid <= 1'b1;
        data_byte <= it.data;
        start_of_image <= it.sof;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    reg_write_t wr;
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (cfg_q.size() != 0) begin
        wr = cfg_q.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= wr.index;
        cfg_data <= wr.value;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    fill_cmd_t got, want, pred;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{pixel_address, pixel_value, repeat_count, clipped, image_done};
        if (expected_q.size() == 0) begin
          flag_error($sformatf("unexpected fill command addr %h", got.addr));
        end else begin
          want = expected_q.pop_front();
          if (got.addr !== want.addr)
            flag_error($sformatf("pixel_address %h, want %h", got.addr, want.addr));
          if (got.value !== want.value)
            flag_error($sformatf("pixel_value %h, want %h", got.value, want.value));
          if (got.count !== want.count)
            flag_error($sformatf("repeat_count %0d, want %0d", got.count, want.count));
          if (got.clip !== want.clip)
            flag_error($sformatf("clipped %b, want %b", got.clip, want.clip));
          if (got.done !== want.done)
            flag_error($sformatf("image_done %b, want %b", got.done, want.done));
        end
      end
      if (in_valid && in_ready) begin
        if (decode_byte(data_byte, start_of_image, pred)) expected_q.push_back(pred);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:      cfg_w = cfg_data;
          REG_IMAGE_HEIGHT:     cfg_h = cfg_data;
          REG_COMPRESSION_MODE: cfg_rle = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    byte_q.push_back('{b, pending_start});
    pending_start = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
    cfg_q.push_back('{index, value});
  endtask

  task automatic commit_regs();
    while (cfg_q.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  task automatic settle();
    while (byte_q.size() != 0 || in_valid || cfg_q.size() != 0 || cfg_valid ||
           expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim(input int common_max);
    case ($urandom_range(0, 19))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd8191;
      4: return 13'd4095;
      5: return DIM_W'($urandom_range(0, 8191));
      default: return DIM_W'($urandom_range(1, common_max));
    endcase
  endfunction

  task automatic send_raw(input bit restart);
    longint w, total;
    w = eff_width();
    total = (((w + 3) >> 2) << 2) * eff_height();
    if (total > 300 || !restart) total = $urandom_range(8, 120);
    pending_start = restart;
    repeat (total) push_byte(BYTE_W'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 2)) push_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_rle(input bit restart);
    longint h;
    int n, r;
    h = eff_height();
    pending_start = restart;
    repeat ($urandom_range(3, 30)) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(1, 255);
        push_byte(BYTE_W'(n));
        push_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (r < 63) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(LIT_MIN, 255)
                                         : $urandom_range(LIT_MIN, 12);
        push_byte(ESC_LEAD);
        push_byte(BYTE_W'(n));
        repeat (n + (n % 2)) push_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (r < 73) begin
        push_byte(ESC_LEAD);
        push_byte(ESC_EOL);
      end else if (r < 85) begin
        push_byte(ESC_LEAD);
        push_byte(ESC_DELTA);
        push_byte(BYTE_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                               : $urandom_range(0, 255)));
        push_byte(BYTE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 2)));
      end else if (r < 95) begin
        push_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        pending_start = 1'b1;
      end
    end
    case ($urandom_range(0, 3))
      0, 1: begin
        push_byte(ESC_LEAD);
        push_byte(ESC_END);
      end
      2: begin
        if (h <= 40) begin
          repeat (h + 1) begin
            push_byte(ESC_LEAD);
            push_byte(ESC_EOL);
          end
        end else begin
          repeat (h / 255 + 2) begin
            push_byte(ESC_LEAD);
            push_byte(ESC_DELTA);
            push_byte(8'd0);
            push_byte(8'd255);
          end
        end
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 1)) push_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    int iter, base, guard;
    bit keep;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // raw 1x1 image: byte before any start, padding, end on last pad, byte after end
    push_byte(8'h5A);
    pending_start = 1'b1;
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h11);
    settle();

    // out-of-range sizes, run-length mode
    write_reg(REG_IMAGE_WIDTH, 13'd8191);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    write_reg(REG_COMPRESSION_MODE, 13'h1FFF);
    commit_regs();
    pending_start = 1'b1;
    push_byte(8'hFF);
    push_byte(8'hAA);
    push_byte(ESC_LEAD);
    push_byte(8'd3);
    push_byte(8'h01);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_byte(8'h00);
    push_byte(ESC_LEAD);
    push_byte(ESC_DELTA);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h55);
    push_byte(ESC_LEAD);
    push_byte(ESC_END);
    settle();

    base = decoded_count;
    iter = 0;
    while (decoded_count - base < RANDOM_ITEMS) begin
      settle();
      no_gaps = (iter >= 2 && iter < 12);
      if (iter == 0) begin
        // full raw image while the receiver holds off
        write_reg(REG_IMAGE_WIDTH, 13'd16);
        write_reg(REG_IMAGE_HEIGHT, 13'd8);
        write_reg(REG_COMPRESSION_MODE, 13'd0);
        commit_regs();
        squeeze_req = 1'b1;
        send_raw(1'b1);
      end else begin
        keep = iter > 1 && $urandom_range(99) < 15;
        if (keep) begin
          case ($urandom_range(0, 3))
            0: write_reg(REG_IMAGE_WIDTH, pick_dim(12));
            1: write_reg(REG_IMAGE_HEIGHT, pick_dim(6));
            2: write_reg(REG_COMPRESSION_MODE, DIM_W'($urandom_range(0, 8191)));
            default: write_reg(REG_SPARE, DIM_W'($urandom_range(0, 8191)));
          endcase
        end else if ($urandom_range(0, 19) == 0) begin
          write_reg(REG_IMAGE_WIDTH, 13'd4096);
          write_reg(REG_IMAGE_HEIGHT, 13'd4096);
          write_reg(REG_COMPRESSION_MODE, DIM_W'($urandom_range(0, 8191)));
        end else begin
          write_reg(REG_IMAGE_WIDTH, pick_dim(12));
          write_reg(REG_IMAGE_HEIGHT, pick_dim(6));
          write_reg(REG_COMPRESSION_MODE, DIM_W'($urandom_range(0, 8191)));
        end
        commit_regs();
        if (cfg_rle) send_rle(!keep || $urandom_range(0, 1));
        else send_raw(!keep || $urandom_range(0, 1));
      end
      iter++;
    end

    while (byte_q.size() != 0 || in_valid) @(negedge clk);
    guard = 0;
    while (expected_q.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_q.size() != 0)
      flag_error($sformatf("%0d fill commands never arrived", expected_q.size()));

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/bmpd_pkg.sv
rtl/bmpd_cfg.sv
rtl/bmpd_front.sv
rtl/bmpd_queue.sv
rtl/bmpd_back.sv
rtl/bitmap_8bit_pixel_stream_decoder_top.sv
rtl/bmpd_checker.sv
dv/bitmap_8bit_pixel_stream_decoder_top_test.sv
